/* rtl/bir_pkg.sv */
// bicubic resampler package: payload structs, register indexes, ctrl/dp structs
// no dependencies
`timescale 1ns / 1ps
package bir_pkg;
  typedef struct packed {
    logic        func;
    logic [11:0] col;
    logic [11:0] row;
    logic signed [15:0] sample;
  } bir_in_t;

  typedef struct packed {
    logic signed [15:0] out_pixel;
    logic               saturated;
  } bir_out_t;

  localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP_X    = 2'd2;
  localparam logic [1:0] REG_STEP_Y    = 2'd3;

  localparam logic FUNC_STORE   = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;     // capture item, start locate
    logic       write;    // store sample
    logic       locate;   // multiply position
    logic       powers;   // t^2/t^3 steps
    logic       rd;       // issue memory read
    logic [1:0] rd_x;     // neighbor column
    logic [1:0] rd_y;     // neighbor row
    logic       acc;      // accumulate read data into row pass
    logic [1:0] acc_x;
    logic       row_done; // finish one row
    logic [1:0] row_k;
    logic       col_pass; // finish column pass
    logic       emit;
  } bir_cmd_t;
endpackage

/* rtl/bir_ctrl.sv */
// bicubic resampler controller: sequences store and compute items
// depends on bir_pkg
`timescale 1ns / 1ps
module bir_ctrl
  import bir_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     func,
  output logic     busy,
  output bir_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_LOC, S_POW, S_READ, S_COL, S_OUT} state_t;
  state_t     state;
  logic [3:0] cnt;
  logic [3:0] cnt_d;    // read issued last cycle
  logic       vld_d;
  logic [1:0] pw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      cnt_d <= '0;
      vld_d <= 1'b0;
      pw    <= '0;
    end else begin
      vld_d <= (state == S_READ);
      cnt_d <= cnt;
      case (state)
        S_IDLE: if (start && func == FUNC_COMPUTE) state <= S_LOC;
        S_LOC:  begin state <= S_POW; pw <= '0; end
        S_POW:  begin
          pw <= pw + 2'd1;
          if (pw == 2'd1) begin state <= S_READ; cnt <= '0; end
        end
        S_READ: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_COL;
        end
        S_COL:  if (!vld_d) state <= S_OUT;
        S_OUT:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.write    = (state == S_IDLE) && start && (func == FUNC_STORE);
    cmd.locate   = (state == S_LOC);
    cmd.powers   = (state == S_POW);
    cmd.rd       = (state == S_READ);
    cmd.rd_x     = cnt[1:0];
    cmd.rd_y     = cnt[3:2];
    cmd.acc      = vld_d;
    cmd.acc_x    = cnt_d[1:0];
    cmd.row_done = vld_d && (cnt_d[1:0] == 2'd3);
    cmd.row_k    = cnt_d[3:2];
    cmd.col_pass = (state == S_COL) && !vld_d;
    cmd.emit     = (state == S_OUT);
  end

  assert property (@(posedge clk) disable iff (rst) cmd.emit |=> !busy)
    else $error("busy after result");
  assert property (@(posedge clk) disable iff (rst) cmd.write |=> !busy)
    else $error("store must not occupy the block");
  assert property (@(posedge clk) disable iff (rst) (busy && !cmd.emit) |=> busy)
    else $error("compute ended early");
endmodule

/* rtl/bir_dp.sv */
// bicubic resampler datapath: image memory, locate, kernel passes, rounding
// depends on bir_pkg
`timescale 1ns / 1ps
module bir_dp
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  bir_cmd_t    cmd,
  input  bir_in_t     item,
  input  logic [8:0]  in_width,
  input  logic [8:0]  in_height,
  input  logic [23:0] step_x,
  input  logic [23:0] step_y,
  output bir_out_t    res
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int F  = FRAC_BITS;
  localparam int RF = 8;

  logic signed [15:0] mem [1 << (XW + YW)];
  logic signed [15:0] rdata;

  logic [11:0] col_q, row_q;
  logic [XW-1:0] xs [4];
  logic [YW-1:0] ys [4];
  logic [F-1:0] tx, ty, tx2, ty2, tx3, ty3;
  logic signed [15:0] px [3];
  logic signed [31:0] rows [4];
  logic signed [63:0] s_row, s_col;

  // clamp size register into [1, max]
  function automatic logic [12:0] clamp_sz(input logic [8:0] v, input int mx);
    logic [12:0] r;
    r = {4'd0, v};
    if (r == 13'd0) r = 13'd1;
    if (r > 13'(mx)) r = 13'(mx);
    return r;
  endfunction

  logic [35:0] posx, posy;
  logic [12:0] lastx, lasty;
  logic [23:0] ix0, iy0;
  logic        past_x, past_y;
  logic [12:0] bx, by;
  assign lastx  = clamp_sz(in_width, MAX_WIDTH) - 13'd1;
  assign lasty  = clamp_sz(in_height, MAX_HEIGHT) - 13'd1;
  assign posx   = col_q * step_x;
  assign posy   = row_q * step_y;
  assign ix0    = 24'(posx >> F);
  assign iy0    = 24'(posy >> F);
  assign past_x = (ix0 >= 24'(lastx));
  assign past_y = (iy0 >= 24'(lasty));
  assign bx     = past_x ? lastx : 13'(ix0);
  assign by     = past_y ? lasty : 13'(iy0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= item.col;
      row_q <= item.row;
    end
    if (cmd.write && {1'b0, item.col} < 13'(MAX_WIDTH) &&
        {1'b0, item.row} < 13'(MAX_HEIGHT))
      mem[{item.row[YW-1:0], item.col[XW-1:0]}] <= item.sample;
    if (cmd.rd)
      rdata <= mem[{ys[cmd.rd_y], xs[cmd.rd_x]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.locate) begin
      tx <= past_x ? '0 : posx[F-1:0];
      ty <= past_y ? '0 : posy[F-1:0];
      xs[0] <= XW'(bx == 0 ? 13'd0 : bx - 13'd1);
      xs[1] <= XW'(bx);
      xs[2] <= XW'(bx + 13'd1 > lastx ? lastx : bx + 13'd1);
      xs[3] <= XW'(bx + 13'd2 > lastx ? lastx : bx + 13'd2);
      ys[0] <= YW'(by == 0 ? 13'd0 : by - 13'd1);
      ys[1] <= YW'(by);
      ys[2] <= YW'(by + 13'd1 > lasty ? lasty : by + 13'd1);
      ys[3] <= YW'(by + 13'd2 > lasty ? lasty : by + 13'd2);
    end
  end

  // powers in two steps, one multiply per axis per step
  logic [2*F-1:0] px2, py2, px3, py3;
  assign px2 = tx * tx;
  assign py2 = ty * ty;
  assign px3 = tx2 * tx;
  assign py3 = ty2 * ty;
  logic pstep;
  always_ff @(posedge clk) begin
    if (cmd.locate) pstep <= 1'b0;
    if (cmd.powers) begin
      pstep <= 1'b1;
      if (!pstep) begin tx2 <= px2[2*F-1:F]; ty2 <= py2[2*F-1:F]; end
      else begin tx3 <= px3[2*F-1:F]; ty3 <= py3[2*F-1:F]; end
    end
  end

  // kernel sum, coefficients by adds
  function automatic logic signed [63:0] ksum(
    input logic [F-1:0] t, t2, t3,
    input logic signed [31:0] a, b, c, d);
    logic signed [35:0] c1, c2, c3;
    c1 = 36'(c) - 36'(a);
    c2 = 36'(a) * 2 - 36'(b) * 5 + 36'(c) * 4 - 36'(d);
    c3 = -36'(a) + 36'(b) * 3 - 36'(c) * 3 + 36'(d);
    return (64'(b) <<< (F + 1)) + $signed({1'b0, t}) * c1
         + $signed({1'b0, t2}) * c2 + $signed({1'b0, t3}) * c3;
  endfunction

  // fourth pixel of a row comes straight from the read register
  assign s_row = ksum(tx, tx2, tx3, 32'(px[0]), 32'(px[1]), 32'(px[2]), 32'(rdata));
  assign s_col = ksum(ty, ty2, ty3, rows[0], rows[1], rows[2], rows[3]);

  logic signed [63:0] r_s, v;
  assign r_s = (s_row + (64'sd1 <<< (F - RF))) >>> (F + 1 - RF);
  assign v   = (s_col + (64'sd1 <<< (F + RF))) >>> (F + 1 + RF);

  always_ff @(posedge clk) begin
    if (cmd.acc && cmd.acc_x != 2'd3) px[cmd.acc_x] <= rdata;
    if (cmd.row_done) rows[cmd.row_k] <= 32'(r_s);
    if (cmd.col_pass) begin
      if (v > 64'sd32767) begin
        res.out_pixel <= 16'sd32767; res.saturated <= 1'b1;
      end else if (v < -64'sd32768) begin
        res.out_pixel <= -16'sd32768; res.saturated <= 1'b1;
      end else begin
        res.out_pixel <= 16'(v); res.saturated <= 1'b0;
      end
    end
  end
endmodule

/* rtl/bicubic_image_resampler_unit.sv */
// compute: locate, powers, 16 reads, then column pass and result
// busy stays high through a compute; start is taken only while busy is low
// store: no result; busy stays low
// rst clears control and registers to defaults; image memory undefined until written
// results cannot be stalled: done pulses one cycle with the result
`timescale 1ns / 1ps
module bicubic_image_resampler_unit
  import bir_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  bir_in_t     in_item,
  output logic        done,
  output bir_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [8:0]  in_width, in_height;
  logic [23:0] step_x, step_y;
  bir_cmd_t    cmd;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= 9'd256;
      in_height <= 9'd256;
      step_x    <= 24'd65536;
      step_y    <= 24'd65536;
    end else if (wr) begin
      case (paddr[3:2])
        REG_IN_WIDTH:  in_width  <= pwdata[8:0];
        REG_IN_HEIGHT: in_height <= pwdata[8:0];
        REG_STEP_X:    step_x    <= pwdata[23:0];
        REG_STEP_Y:    step_y    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IN_WIDTH:  prdata = {23'd0, in_width};
      REG_IN_HEIGHT: prdata = {23'd0, in_height};
      REG_STEP_X:    prdata = {8'd0, step_x};
      REG_STEP_Y:    prdata = {8'd0, step_y};
      default:       prdata = '0;
    endcase
  end

  bir_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(in_item.func),
    .busy(busy), .cmd(cmd)
  );

  bir_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .item(in_item),
    .in_width(in_width), .in_height(in_height),
    .step_x(step_x), .step_y(step_y), .res(result)
  );

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.emit;
  end
endmodule

/* verif/tb_bicubic_image_resampler_unit.sv */
// testbench for bicubic_image_resampler_unit: stores small source images, then
// checks every interpolated pixel against a bit-exact fixed-point predictor
// depends on rtl/bir_pkg.sv and rtl/bicubic_image_resampler_unit.sv
`timescale 1ns / 1ps
module tb_bicubic_image_resampler_unit;
  import bir_pkg::*;

  localparam int  FRAC      = 16;
  localparam int  MAX_DIM   = 256;
  localparam int  LIMIT     = 1000000;
  localparam int  N_PHASES  = 12;
  localparam int  PER_PHASE = 60;

  class bir_scoreboard;
    logic signed [15:0] pix [MAX_DIM*MAX_DIM];
    bit                 written [MAX_DIM*MAX_DIM];
    logic [8:0]         width_r, height_r;
    logic [23:0]        step_x_r, step_y_r;
    bir_out_t           expected_q [$];
    int                 mismatches, checked, sat_seen, stores, computes;

    function new();
      width_r  = 256;
      height_r = 256;
      step_x_r = 24'h010000;
      step_y_r = 24'h010000;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_IN_WIDTH:  width_r  = v[8:0];
        REG_IN_HEIGHT: height_r = v[8:0];
        REG_STEP_X:    step_x_r = v[23:0];
        REG_STEP_Y:    step_y_r = v[23:0];
        default: ;
      endcase
    endfunction

    function longint eff_size(logic [8:0] v);
      if (v == 0) return 1;
      return (v > MAX_DIM) ? MAX_DIM : longint'(v);
    endfunction

    // neighbor indices with edge clamp, fraction zeroed at or past the last sample
    function void locate(input longint coord, input longint step, input longint size,
                         output longint idx[4], output longint t);
      longint last, pos, i0;
      last = size - 1;
      pos  = coord * step;
      i0   = pos >> FRAC;
      t    = pos & ((64'd1 << FRAC) - 1);
      if (i0 >= last) begin
        i0 = last;
        t  = 0;
      end
      idx[0] = (i0 == 0) ? 0 : i0 - 1;
      idx[1] = i0;
      idx[2] = (i0 + 1 > last) ? last : i0 + 1;
      idx[3] = (i0 + 2 > last) ? last : i0 + 2;
    endfunction

    function longint cubic(longint t, longint t2, longint t3,
                           longint a, longint b, longint c, longint d);
      return 2 * b * (64'sd1 <<< FRAC) + t * (c - a) + t2 * (2*a - 5*b + 4*c - d)
             + t3 * (-a + 3*b - 3*c + d);
    endfunction

    function void note_input(bir_in_t it);
      longint xs[4], ys[4], tx, ty, tx2, tx3, ty2, ty3, rows[4], s, v;
      bir_out_t e;
      if (it.func == FUNC_STORE) begin
        stores++;
        if (it.col < MAX_DIM && it.row < MAX_DIM) begin
          pix[it.row * MAX_DIM + it.col]     = it.sample;
          written[it.row * MAX_DIM + it.col] = 1;
        end
        return;
      end
      computes++;
      locate(it.col, step_x_r, eff_size(width_r), xs, tx);
      locate(it.row, step_y_r, eff_size(height_r), ys, ty);
      tx2 = (tx * tx) >> FRAC;
      tx3 = (tx2 * tx) >> FRAC;
      ty2 = (ty * ty) >> FRAC;
      ty3 = (ty2 * ty) >> FRAC;
      for (int k = 0; k < 4; k++) begin
        s = cubic(tx, tx2, tx3, pix[ys[k]*MAX_DIM + xs[0]], pix[ys[k]*MAX_DIM + xs[1]],
                  pix[ys[k]*MAX_DIM + xs[2]], pix[ys[k]*MAX_DIM + xs[3]]);
        // row values keep 8 fraction bits
        rows[k] = (s + (64'sd1 <<< (FRAC - 8))) >>> (FRAC - 7);
      end
      s = cubic(ty, ty2, ty3, rows[0], rows[1], rows[2], rows[3]);
      v = (s + (64'sd1 <<< (FRAC + 8))) >>> (FRAC + 9);
      e.saturated = 0;
      if (v > 32767) begin
        v = 32767;
        e.saturated = 1;
      end
      if (v < -32768) begin
        v = -32768;
        e.saturated = 1;
      end
      e.out_pixel = v[15:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(bir_out_t r);
      bir_out_t e;
      checked++;
      if (r.saturated) sat_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pixel=%0d sat=%0b",
                                       r.out_pixel, r.saturated);
        return;
      end
      e = expected_q.pop_front();
      if (r.out_pixel !== e.out_pixel || r.saturated !== e.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected %0d sat %0b, got %0d sat %0b",
                   e.out_pixel, e.saturated, r.out_pixel, r.saturated);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  bir_in_t     in_item = '0;
  logic        done;
  bir_out_t    result;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bir_scoreboard sb = new();
  int            cycles = 0;
  int            max_gap = 12;

  bicubic_image_resampler_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("bicubic_image_resampler_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  task automatic send_item(bir_in_t it);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bir_in_t make_item(logic f, int c, int r, logic [15:0] s);
    bir_in_t it;
    it.func   = f;
    it.col    = 12'(c);
    it.row    = 12'(r);
    it.sample = s;
    return it;
  endfunction

  // every sample a compute can reach must be written first
  task automatic fill_region();
    longint w, h;
    w = sb.eff_size(sb.width_r);
    h = sb.eff_size(sb.height_r);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!sb.written[r*MAX_DIM + c]) send_item(make_item(FUNC_STORE, c, r, rand_sample()));
  endtask

  task automatic random_items(int n);
    int w, h;
    w = int'(sb.eff_size(sb.width_r));
    h = int'(sb.eff_size(sb.height_r));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: send_item(make_item(FUNC_STORE, $urandom_range(0, w - 1),
                                  $urandom_range(0, h - 1), rand_sample()));
        2:    send_item(make_item(FUNC_STORE, $urandom_range(0, 4095),
                                  $urandom_range(256, 4095), 16'($urandom)));
        3:    send_item(make_item(FUNC_COMPUTE, $urandom_range(0, 4095),
                                  $urandom_range(0, 4095), 16'($urandom)));
        default: send_item(make_item(FUNC_COMPUTE, $urandom_range(0, 63),
                                     $urandom_range(0, 63), 16'($urandom)));
      endcase
    end
  endtask

  task automatic set_phase(logic [31:0] w, logic [31:0] h, logic [31:0] sx, logic [31:0] sy);
    drain();
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    max_gap = $urandom_range(0, 1) ? 12 : 0;
    fill_region();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: checkerboard extremes force overshoot and clipping
    set_phase(4, 4, 32'h18000, 32'h0C000);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_item(make_item(FUNC_STORE, c, r, ((r + c) % 2) ? 16'h8000 : 16'h7FFF));
    send_item(make_item(FUNC_STORE, 4095, 4095, 16'hFFFF));
    send_item(make_item(FUNC_STORE, 255, 4095, 16'h1234));
    send_item(make_item(FUNC_COMPUTE, 0, 0, 16'hFFFF));
    send_item(make_item(FUNC_COMPUTE, 1, 1, 16'h0000));
    send_item(make_item(FUNC_COMPUTE, 1, 3, 16'h0000));
    send_item(make_item(FUNC_COMPUTE, 2, 1, 16'h0000));
    send_item(make_item(FUNC_COMPUTE, 4095, 0, 16'h0000));
    send_item(make_item(FUNC_COMPUTE, 0, 4095, 16'h0000));
    send_item(make_item(FUNC_COMPUTE, 4095, 4095, 16'h0000));
    send_item(make_item(FUNC_STORE, 1, 1, 16'h0000));
    send_item(make_item(FUNC_COMPUTE, 1, 1, 16'h0000));

    // register extremes, including out-of-range size values
    set_phase(2, 2, 32'h010000, 32'h010000);
    random_items(PER_PHASE);
    set_phase(256, 2, 32'hFFFFFF, 32'h000001);
    random_items(PER_PHASE);
    set_phase(0, 300, 32'h000000, 32'h008000);
    random_items(PER_PHASE);
    set_phase(511, 3, 32'h000100, 32'hFFFFFF);
    random_items(PER_PHASE);
    for (int p = 5; p < N_PHASES; p++) begin
      set_phase($urandom_range(2, 16), $urandom_range(2, 16),
                $urandom_range(0, 1) ? $urandom_range(0, 32'h3FFFF) : $urandom,
                $urandom_range(0, 1) ? $urandom_range(0, 32'h3FFFF) : $urandom);
      random_items(PER_PHASE);
    end

    drain();
    $display("covered %0d stores and %0d computes over %0d register settings",
             sb.stores, sb.computes, N_PHASES);
    $display("%0d results checked, %0d clipped, %0d mismatches",
             sb.checked, sb.sat_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("bicubic_image_resampler_unit regression: pass");
    else
      $display("bicubic_image_resampler_unit regression: fail");
    $finish;
  end
endmodule
